[sv/sonde_frame_block_deframer_core_macros.svh]
// assertion helpers for the deframer checker
`ifndef SONDE_FRAME_BLOCK_DEFRAMER_CORE_MACROS_SVH
`define SONDE_FRAME_BLOCK_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication, sampled on clk, off during reset
`define SFD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

[sv/sfd_pkg.sv]
`timescale 1ns / 1ps
package sfd_pkg;

	localparam int FRAME_BYTES  = 312;
	localparam int MAX_STEPS    = 40;
	localparam int FIRST_PARSED = 49;
	localparam int KEY_OFFSET   = 8;
	localparam int POS_W        = 10;
	localparam int STEP_W       = 6;

	localparam logic [7:0]  STATUS_ID  = 8'h79;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]  STATUS_MIN = 8'd10;

	localparam logic [7:0] KEY_TABLE [64] = '{
		8'h96, 8'h83, 8'h3E, 8'h51, 8'hB1, 8'h49, 8'h08, 8'h98,
		8'h32, 8'h05, 8'h59, 8'h0E, 8'hF9, 8'h44, 8'hC6, 8'h26,
		8'h21, 8'h60, 8'hC2, 8'hEA, 8'h79, 8'h5D, 8'h6D, 8'hA1,
		8'h54, 8'h69, 8'h47, 8'h0C, 8'hDC, 8'hE8, 8'h5C, 8'hF1,
		8'hF7, 8'h76, 8'h82, 8'h7F, 8'h07, 8'h99, 8'hA2, 8'h2C,
		8'h93, 8'h7C, 8'h30, 8'h63, 8'hF5, 8'h10, 8'h2E, 8'h61,
		8'hD0, 8'hBC, 8'hB4, 8'hB6, 8'h06, 8'hAA, 8'hF4, 8'h23,
		8'h78, 8'h6E, 8'h3B, 8'hAE, 8'hBF, 8'h7B, 8'h4C, 8'hC1
	};

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HEAD  = 3'd1,
		PH_HUNT  = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_CRCLO = 3'd5,
		PH_CRCHI = 3'd6,
		PH_STOP  = 3'd7
	} phase_t;

	// one classified byte as the front hands it to the parser
	typedef struct packed {
		logic             live;
		logic             start;
		logic             last;
		logic [POS_W-1:0] pos;
		logic [7:0]       cbyte;
	} entry_t;

	typedef struct packed {
		logic [7:0] clear_byte;
		logic       in_payload;
		logic       block_end;
		logic [7:0] block_kind;
		logic [7:0] block_size;
		logic       crc_good;
		logic       frame_end;
		logic       frame_good;
	} result_t;

	function automatic logic [7:0] bit_flip(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[sv/sfd_ifs.sv]
`timescale 1ns / 1ps
interface sfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;
	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] clear_byte;
	logic       in_payload;
	logic       block_end;
	logic [7:0] block_kind;
	logic [7:0] block_size;
	logic       crc_good;
	logic       frame_end;
	logic       frame_good;
	modport source (output valid, output clear_byte, output in_payload, output block_end,
		output block_kind, output block_size, output crc_good, output frame_end,
		output frame_good, input ready);
	modport sink (input valid, input clear_byte, input in_payload, input block_end,
		input block_kind, input block_size, input crc_good, input frame_end,
		input frame_good, output ready);
endinterface

[sv/sfd_queue.sv]
`timescale 1ns / 1ps
module sfd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfd_pkg::entry_t push_entry,
	output logic            not_full,
	input  logic            pop,
	output logic            head_valid,
	output sfd_pkg::entry_t head_entry
);
	import sfd_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_full   = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[sv/sfd_front.sv]
`timescale 1ns / 1ps
module sfd_front (
	input  logic            clk,
	input  logic            arst_n,
	sfd_in_if.sink          byte_ch,
	input  logic            queue_ready,
	output logic            push,
	output sfd_pkg::entry_t push_entry
);
	import sfd_pkg::*;

	logic             active_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos;
	logic [5:0]       key_idx;
	logic             live;
	logic             last;

	assign byte_ch.ready = queue_ready;
	assign push          = byte_ch.valid & queue_ready;

	always_comb begin
		pos     = byte_ch.frame_start ? '0 : pos_q;
		key_idx = 6'(pos + POS_W'(KEY_OFFSET));
		live    = byte_ch.frame_start | active_q;
		last    = live & (pos == POS_W'(FRAME_BYTES - 1));
		push_entry.live  = live;
		push_entry.start = byte_ch.frame_start;
		push_entry.last  = last;
		push_entry.pos   = pos;
		push_entry.cbyte = bit_flip(byte_ch.rx_byte) ^ KEY_TABLE[key_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else if (push && live) begin
			if (last) begin
				active_q <= 1'b0;
				pos_q    <= '0;
			end else begin
				active_q <= 1'b1;
				pos_q    <= pos + POS_W'(1);
			end
		end
	end
endmodule

[sv/sfd_back.sv]
`timescale 1ns / 1ps
module sfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  sfd_pkg::entry_t  head_entry,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output sfd_pkg::result_t out_result
);
	import sfd_pkg::*;

	phase_t            phase_q, phase_n;
	logic [15:0]       crc_q, crc_n;
	logic [7:0]        kind_q, kind_n;
	logic [7:0]        size_q, size_n;
	logic [7:0]        idx_q, idx_n;
	logic [7:0]        crclo_q, crclo_n;
	logic [STEP_W-1:0] step_q, step_n;
	logic              status_q, status_n;
	logic              idchar_q, idchar_n;
	logic              pend_q, pend_n;

	logic              valid_q;
	result_t           result_q;
	result_t           res;

	// candidate id evaluation, shared by hunt and length slip
	phase_t            cand_phase;
	logic [STEP_W-1:0] cand_step;
	logic              cand_status;
	logic              cand_kind_ld;

	logic [7:0]        c;
	logic [POS_W:0]    p_ext;
	logic              crc_match;

	assign c     = head_entry.cbyte;
	assign p_ext = {1'b0, head_entry.pos};
	assign pop   = head_valid & (~valid_q | out_ready);

	assign out_valid  = valid_q;
	assign out_result = result_q;

	always_comb begin
		cand_phase   = PH_HUNT;
		cand_step    = step_q;
		cand_status  = 1'b0;
		cand_kind_ld = 1'b0;
		if (step_q >= STEP_W'(MAX_STEPS)) begin
			cand_phase = PH_STOP;
		end else begin
			cand_step = step_q + STEP_W'(1);
			if (c == 8'd0) begin
				cand_phase = PH_HUNT;
			end else begin
				cand_status = (c == STATUS_ID);
				if (p_ext + (POS_W+1)'(4) > (POS_W+1)'(FRAME_BYTES)) begin
					cand_phase = PH_STOP;
				end else begin
					cand_phase   = PH_LEN;
					cand_kind_ld = 1'b1;
				end
			end
		end
	end

	assign crc_match = ({c, crclo_q} == crc_q);

	always_comb begin
		phase_n  = phase_q;
		crc_n    = crc_q;
		kind_n   = kind_q;
		size_n   = size_q;
		idx_n    = idx_q;
		crclo_n  = crclo_q;
		step_n   = step_q;
		status_n = status_q;
		idchar_n = idchar_q;
		pend_n   = pend_q;
		res      = '0;
		if (head_entry.live && head_entry.start) begin
			// new frame, position zero is always a header byte
			phase_n        = PH_HEAD;
			crc_n          = CRC_INIT;
			kind_n         = '0;
			size_n         = '0;
			idx_n          = '0;
			crclo_n        = '0;
			step_n         = '0;
			status_n       = 1'b0;
			idchar_n       = 1'b0;
			pend_n         = 1'b0;
			res.clear_byte = c;
		end else if (head_entry.live) begin
			res.clear_byte = c;
			case (phase_q)
				PH_HEAD: begin
					if (head_entry.pos >= POS_W'(FIRST_PARSED - 1)) begin
						phase_n = PH_HUNT;
					end
				end
				PH_HUNT: begin
					phase_n  = cand_phase;
					step_n   = cand_step;
					status_n = status_q | cand_status;
					if (cand_kind_ld) begin
						kind_n = c;
					end
				end
				PH_LEN: begin
					if (c == 8'd0 ||
						p_ext + (POS_W+1)'(c) + (POS_W+1)'(3) > (POS_W+1)'(FRAME_BYTES)) begin
						// slip: the length byte becomes the next id candidate
						phase_n  = cand_phase;
						step_n   = cand_step;
						status_n = status_q | cand_status;
						if (cand_kind_ld) begin
							kind_n = c;
						end
					end else begin
						size_n  = c;
						idx_n   = '0;
						crc_n   = CRC_INIT;
						pend_n  = 1'b0;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					res.in_payload = 1'b1;
					res.block_kind = kind_q;
					res.block_size = size_q;
					crc_n          = crc_byte(crc_q, c);
					if (idx_q == 8'd2) begin
						pend_n = (c != 8'd0);
					end
					idx_n = idx_q + 8'd1;
					if (idx_q + 8'd1 >= size_q) begin
						phase_n = PH_CRCLO;
					end
				end
				PH_CRCLO: begin
					res.block_kind = kind_q;
					res.block_size = size_q;
					crclo_n        = c;
					phase_n        = PH_CRCHI;
				end
				PH_CRCHI: begin
					res.block_end  = 1'b1;
					res.block_kind = kind_q;
					res.block_size = size_q;
					res.crc_good   = crc_match;
					if (crc_match && kind_q == STATUS_ID && size_q >= STATUS_MIN) begin
						idchar_n = pend_q;
					end
					phase_n = PH_HUNT;
				end
				default: begin
				end
			endcase
			if (head_entry.last) begin
				res.frame_end  = 1'b1;
				res.frame_good = status_n & idchar_n;
				phase_n        = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			crc_q    <= CRC_INIT;
			kind_q   <= '0;
			size_q   <= '0;
			idx_q    <= '0;
			crclo_q  <= '0;
			step_q   <= '0;
			status_q <= 1'b0;
			idchar_q <= 1'b0;
			pend_q   <= 1'b0;
		end else if (pop) begin
			phase_q  <= phase_n;
			crc_q    <= crc_n;
			kind_q   <= kind_n;
			size_q   <= size_n;
			idx_q    <= idx_n;
			crclo_q  <= crclo_n;
			step_q   <= step_n;
			status_q <= status_n;
			idchar_q <= idchar_n;
			pend_q   <= pend_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res;
		end
	end
endmodule

[sv/sonde_frame_block_deframer_core.sv]
`timescale 1ns / 1ps
// Frame deframer: takes one byte per cycle while the queue has room and gives one result
// per byte, in order, held in the queue, then in the result register. The front
// bit-reverses and descrambles each byte and tags it with its frame position; a two-entry
// queue hands it to the block parser, whose byte-wide CRC update and id/length checks set
// the one-byte-per-cycle pace. Bytes outside a frame come back with every field zero, and
// frame_start at any time starts a new frame. No clearing pass follows reset.
module sonde_frame_block_deframer_core (
	input logic        clk,
	input logic        arst_n,
	sfd_in_if.sink     byte_ch,
	sfd_out_if.source  result_ch
);
	import sfd_pkg::*;

	logic    push;
	entry_t  push_entry;
	logic    queue_ready;
	logic    pop;
	logic    head_valid;
	entry_t  head_entry;
	result_t res;

	sfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_ch     (byte_ch),
		.queue_ready (queue_ready),
		.push        (push),
		.push_entry  (push_entry)
	);

	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.not_full   (queue_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	sfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (result_ch.valid),
		.out_ready  (result_ch.ready),
		.out_result (res)
	);

	assign result_ch.clear_byte = res.clear_byte;
	assign result_ch.in_payload = res.in_payload;
	assign result_ch.block_end  = res.block_end;
	assign result_ch.block_kind = res.block_kind;
	assign result_ch.block_size = res.block_size;
	assign result_ch.crc_good   = res.crc_good;
	assign result_ch.frame_end  = res.frame_end;
	assign result_ch.frame_good = res.frame_good;
endmodule

[sv/sfd_checker.sv]
`timescale 1ns / 1ps
`include "sonde_frame_block_deframer_core_macros.svh"
module sfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       in_payload,
	input logic       block_end,
	input logic [7:0] block_size,
	input logic       crc_good,
	input logic       frame_end,
	input logic       frame_good
);
	// crc bytes are never data bytes
	`SFD_ASSERT_IMP(a_end_not_payload, out_valid && block_end, !in_payload)
	// crc verdict only on the closing crc byte
	`SFD_ASSERT_IMP(a_crc_only_at_end, out_valid && !block_end, !crc_good)
	// a finished block always had a nonzero length
	`SFD_ASSERT_IMP(a_end_has_size, out_valid && block_end, block_size != 8'd0)
	// frame verdict only on the last byte
	`SFD_ASSERT_IMP(a_good_only_at_end, out_valid && !frame_end, !frame_good)
	// a stalled request stays offered
	`SFD_ASSERT_NXT(a_valid_holds, out_valid && !out_ready, out_valid)
endmodule

bind sonde_frame_block_deframer_core sfd_checker u_sfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.in_payload (result_ch.in_payload),
	.block_end  (result_ch.block_end),
	.block_size (result_ch.block_size),
	.crc_good   (result_ch.crc_good),
	.frame_end  (result_ch.frame_end),
	.frame_good (result_ch.frame_good)
);
